/* rtl/lpf_pkg.sv */
// Shared constants, register codes and a helper function for the pair force pipeline.
`timescale 1ns / 1ps
`default_nettype none

package lpf_pkg;

   // Quotient bits of the periodic fold dividers and of the u and force dividers.
   localparam int FOLD_Q_W = 34;
   localparam int DIV_Q_W  = 64;
   // Latency of the split 64 by 64 multiplier.
   localparam int MUL_LAT  = 2;

   localparam logic [63:0] CAP63     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [46:0] FORCE_MAX = 47'h7FFF_FFFF_FFFF;
   localparam logic [30:0] CBRT2_Q30 = 31'd1352829926;
   localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BOX_X   = 3'd0,
      CSR_BOX_Y   = 3'd1,
      CSR_BOX_Z   = 3'd2,
      CSR_SIGMA   = 3'd3,
      CSR_EPSILON = 3'd4
   } csr_index_type;

   // Take a 128-bit product down by 32 bits and cap it at 2^63-1.
   function automatic logic [63:0] cap_shr32(input logic [127:0] x);
      logic [63:0] r;
      r = (|x[127:95]) ? CAP63 : x[95:32];
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/lpf_delay.sv */
// Payload delay line with a common clock enable.
`timescale 1ns / 1ps
`default_nettype none

module lpf_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         ce,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   // Shift the whole line one place on each enabled cycle.
   always_ff @(posedge clock) begin
      if (ce) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/lpf_mul.sv */
// Two-stage unsigned 64 by 64 multiplier built from four 32 by 32 partial products.
`timescale 1ns / 1ps
`default_nettype none

module lpf_mul (
   input  logic          clock,
   input  logic          ce,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic [127:0]  p
);

   logic [63:0]  pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [127:0] p_ff, p_in;

   // First stage: the four partial products.
   always_ff @(posedge clock) begin
      if (ce) begin
         pp_ll_ff <= 64'(a[31:0])  * 64'(b[31:0]);
         pp_lh_ff <= 64'(a[31:0])  * 64'(b[63:32]);
         pp_hl_ff <= 64'(a[63:32]) * 64'(b[31:0]);
         pp_hh_ff <= 64'(a[63:32]) * 64'(b[63:32]);
      end
   end

   // Second stage: align and add the partial products.
   always_comb begin
      p_in = {pp_hh_ff, pp_ll_ff} + {32'b0, pp_lh_ff, 32'b0} + {32'b0, pp_hl_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

/* rtl/lpf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module lpf_div #(
   parameter int D_W = 64,
   parameter int Q_W = 64
) (
   input  logic           clock,
   input  logic           ce,
   input  logic [D_W-1:0] num_hi,
   input  logic [Q_W-1:0] num_lo,
   input  logic [D_W-1:0] den,
   output logic [Q_W-1:0] quo,
   output logic           ovf
);

   logic [D_W-1:0] rem_ff [Q_W];
   logic [D_W-1:0] rem_in [Q_W];
   logic [Q_W-1:0] lo_ff  [Q_W];
   logic [Q_W-1:0] lo_in  [Q_W];
   logic [Q_W-1:0] quo_ff [Q_W];
   logic [Q_W-1:0] quo_in [Q_W];
   logic [D_W-1:0] den_ff [Q_W];
   logic [D_W-1:0] den_in [Q_W];
   logic           ovf_ff [Q_W];
   logic           ovf_in [Q_W];

   // One shift and trial subtraction for each stage.
   always_comb begin
      logic [D_W-1:0] src_rem;
      logic [Q_W-1:0] src_lo;
      logic [Q_W-1:0] src_quo;
      logic [D_W-1:0] src_den;
      logic [D_W:0]   trial;
      logic           bit_q;
      for (int i = 0; i < Q_W; i++) begin
         if (i == 0) begin
            src_rem   = num_hi;
            src_lo    = num_lo;
            src_quo   = '0;
            src_den   = den;
            ovf_in[i] = (num_hi >= den);
         end else begin
            src_rem   = rem_ff[i-1];
            src_lo    = lo_ff[i-1];
            src_quo   = quo_ff[i-1];
            src_den   = den_ff[i-1];
            ovf_in[i] = ovf_ff[i-1];
         end
         trial = {src_rem, src_lo[Q_W-1]};
         bit_q = (trial >= {1'b0, src_den});
         if (bit_q) begin
            rem_in[i] = D_W'(trial - {1'b0, src_den});
         end else begin
            rem_in[i] = trial[D_W-1:0];
         end
         lo_in[i]  = {src_lo[Q_W-2:0], 1'b0};
         quo_in[i] = {src_quo[Q_W-2:0], bit_q};
         den_in[i] = src_den;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < Q_W; i++) begin
            rem_ff[i] <= rem_in[i];
            lo_ff[i]  <= lo_in[i];
            quo_ff[i] <= quo_in[i];
            den_ff[i] <= den_in[i];
            ovf_ff[i] <= ovf_in[i];
         end
      end
   end

   assign quo = quo_ff[Q_W-1];
   assign ovf = ovf_ff[Q_W-1];

endmodule

`default_nettype wire

/* rtl/lj_pair_force_wca.sv */
// Top level of the Lennard-Jones pair force pipeline with a repulsive cutoff.
//
//   channel  direction  beat contents
//   req_     in         positions of atoms i and j, chain ids
//   rsp_     out        force on atom i per axis, in_range flag in tuser
//   csr_     in         register index and value (box lengths, sigma, epsilon)
//
// One pair enters per cycle unless an untaken rsp_ beat holds the pipeline.
// The latency is set by the 34-step periodic fold dividers and the two
// 64-step dividers (sigma^2/r2 and the per-axis force division).
// Reset clears the pipeline valid bits and sets every configuration register to 1.0.
// A rsp_ beat that is not taken holds the whole pipeline, and req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module lj_pair_force_wca
   import lpf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, chain_a, chain_b
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z
   output logic [143:0] rsp_tdata,
   // in_range
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata
);

   localparam int FRONT_LAT = 1 + FOLD_Q_W + 5;
   localparam int B_DLY     = DIV_Q_W + 1 + 2 * (MUL_LAT + 1) + 1 + 2 * (MUL_LAT + 1);
   localparam int LAT       = FRONT_LAT + B_DLY + MUL_LAT + 1 + DIV_Q_W + 1;
   localparam logic [30:0] ONE_FX = 31'(1) << FRAC_BITS;

   logic           ce;
   logic [LAT-1:0] valid_ff;

   logic [2:0][30:0] box_ff;
   logic [30:0]      sigma_ff, eps_ff;
   logic [61:0]      sig2_ff;
   logic [60:0]      cut_hi_ff;
   logic [62:0]      cut_lo_ff;
   logic [62:0]      cutoff_ff;
   logic [36:0]      eps48_ff;

   // Front stages
   logic [2:0][32:0] d1_ff, d1_in;
   logic             same1_ff, same1_in;
   logic [2:0][31:0] ad1;
   logic [2:0][33:0] fold_num;
   logic [2:0][31:0] fold_den;
   logic [2:0][33:0] fold_q;
   logic [99:0]      front_dly;
   logic [2:0][32:0] d2_src;
   logic             same2_src;
   logic [2:0][63:0] prod2_ff, prod2_in;
   logic [2:0][32:0] d2_ff;
   logic             same2_ff;
   logic [2:0][31:0] ad3_ff, ad3_in;
   logic [2:0]       neg3_ff, neg3_in;
   logic             same3_ff;
   logic [2:0][63:0] sq4_ff, sq4_in;
   logic [2:0][31:0] ad4_ff, ad5_ff, ad6_ff;
   logic [2:0]       neg4_ff, neg5_ff, neg6_ff;
   logic             same4_ff, same5_ff;
   logic [63:0]      r2_5_ff, r2_5_in, r2_6_ff;
   logic             inr6_ff, inr6_in, calc6_ff, calc6_in;

   // Potential chain
   logic [63:0]  u_q;
   logic         u_ovf;
   logic [63:0]  u7_ff, u7_in, u7_dly;
   logic [127:0] uu_p, uuu_p, gp_p, kp_p;
   logic [63:0]  u2_ff, s6_ff, s6b_ff, hm_ff, g_ff, k_ff;
   logic         gneg_ff, gneg_k;

   // Back stages
   logic [164:0]      bund_b;
   logic [63:0]       r2_b;
   logic [2:0][31:0]  ad_b;
   logic [2:0]        neg_b;
   logic              inr_b, calc_b;
   logic [2:0][127:0] fp_p;
   logic [2:0][127:0] fnum_ff, fnum_in;
   logic [69:0]       bund_c;
   logic [63:0]       r2_c;
   logic [2:0]        neg_c;
   logic              inr_c, calc_c, gneg_c;
   logic [5:0]        bund_d;
   logic [2:0]        neg_d;
   logic              inr_d, calc_d, gneg_d;
   logic [2:0][63:0]  fq;
   logic [2:0]        fovf;
   logic [2:0][47:0]  force_ff, force_in;
   logic              inr_out_ff;

   // Handshake: the pipeline moves unless a result beat waits unaccepted.
   assign ce         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = ce;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {force_ff[2], force_ff[1], force_ff[0]};
   assign rsp_tuser  = inr_out_ff;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff   <= {ONE_FX, ONE_FX, ONE_FX};
         sigma_ff <= ONE_FX;
         eps_ff   <= ONE_FX;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_X:   box_ff[0] <= csr_wdata;
            CSR_BOX_Y:   box_ff[1] <= csr_wdata;
            CSR_BOX_Z:   box_ff[2] <= csr_wdata;
            CSR_SIGMA:   sigma_ff  <= csr_wdata;
            CSR_EPSILON: eps_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Terms derived from the registers; they settle long before a beat needs them.
   always_ff @(posedge clock) begin
      sig2_ff   <= 62'(sigma_ff) * 62'(sigma_ff);
      cut_hi_ff <= 61'(sig2_ff[61:32]) * 61'(CBRT2_Q30);
      cut_lo_ff <= 63'(sig2_ff[31:0]) * 63'(CBRT2_Q30);
      cutoff_ff <= 63'(({cut_hi_ff, 32'b0} + 93'(cut_lo_ff)) >> 30);
      eps48_ff  <= {1'b0, eps_ff, 5'b0} + {2'b0, eps_ff, 4'b0};
   end

   // Separation per axis and the chain test.
   always_comb begin
      logic [32:0] neg33;
      for (int c = 0; c < 3; c++) begin
         d1_in[c] = {req_tdata[32*c+31], req_tdata[32*c +: 32]}
                  - {req_tdata[96+32*c+31], req_tdata[96+32*c +: 32]};
         neg33       = 33'(-d1_ff[c]);
         ad1[c]      = d1_ff[c][32] ? neg33[31:0] : d1_ff[c][31:0];
         fold_num[c] = {1'b0, ad1[c], 1'b0} + 34'(box_ff[c]);
         fold_den[c] = {box_ff[c], 1'b0};
      end
      same1_in = (req_tdata[207:192] == req_tdata[223:208]);
   end

   // Image count n = (2|d| + L) / (2L) per axis.
   for (genvar c = 0; c < 3; c++) begin : g_fold
      lpf_div #(.D_W(32), .Q_W(FOLD_Q_W)) u_fold_div (
         .clock  (clock),
         .ce     (ce),
         .num_hi (32'b0),
         .num_lo (fold_num[c]),
         .den    (fold_den[c]),
         .quo    (fold_q[c]),
         .ovf    ()
      );
   end

   lpf_delay #(.W(100), .DEPTH(FOLD_Q_W)) u_front_dly (
      .clock (clock),
      .ce    (ce),
      .din   ({d1_ff, same1_ff}),
      .dout  (front_dly)
   );
   assign {d2_src, same2_src} = front_dly;

   // Fold, square and sum the separations, then test the cutoff.
   always_comb begin
      logic [63:0] dx64;
      logic [63:0] t64;
      logic [32:0] d3;
      logic [32:0] n3;
      logic [65:0] sum66;
      for (int c = 0; c < 3; c++) begin
         prod2_in[c] = 64'(fold_q[c][32:0]) * 64'(box_ff[c]);
         dx64 = {{31{d2_ff[c][32]}}, d2_ff[c]};
         t64  = d2_ff[c][32] ? (dx64 + prod2_ff[c]) : (dx64 - prod2_ff[c]);
         d3   = (box_ff[c] == 31'd0) ? d2_ff[c] : t64[32:0];
         n3   = 33'(-d3);
         ad3_in[c]  = d3[32] ? n3[31:0] : d3[31:0];
         neg3_in[c] = d3[32];
         sq4_in[c]  = 64'(ad3_ff[c]) * 64'(ad3_ff[c]);
      end
      sum66   = 66'(sq4_ff[0]) + 66'(sq4_ff[1]) + 66'(sq4_ff[2]);
      r2_5_in = (|sum66[65:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum66[63:0];
      inr6_in  = !same5_ff && (r2_5_ff < {1'b0, cutoff_ff});
      calc6_in = inr6_in && (r2_5_ff != 64'd0);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d1_ff    <= d1_in;
         same1_ff <= same1_in;
         prod2_ff <= prod2_in;
         d2_ff    <= d2_src;
         same2_ff <= same2_src;
         ad3_ff   <= ad3_in;
         neg3_ff  <= neg3_in;
         same3_ff <= same2_ff;
         sq4_ff   <= sq4_in;
         ad4_ff   <= ad3_ff;
         neg4_ff  <= neg3_ff;
         same4_ff <= same3_ff;
         r2_5_ff  <= r2_5_in;
         ad5_ff   <= ad4_ff;
         neg5_ff  <= neg4_ff;
         same5_ff <= same4_ff;
         r2_6_ff  <= r2_5_ff;
         ad6_ff   <= ad5_ff;
         neg6_ff  <= neg5_ff;
         inr6_ff  <= inr6_in;
         calc6_ff <= calc6_in;
      end
   end

   // u = sigma^2 / r2 in Q.32.
   lpf_div #(.D_W(64), .Q_W(DIV_Q_W)) u_u_div (
      .clock  (clock),
      .ce     (ce),
      .num_hi ({34'b0, sig2_ff[61:32]}),
      .num_lo ({sig2_ff[31:0], 32'b0}),
      .den    (r2_6_ff),
      .quo    (u_q),
      .ovf    (u_ovf)
   );

   assign u7_in = (u_ovf || u_q[63]) ? CAP63 : u_q;

   lpf_mul u_mul_uu (.clock(clock), .ce(ce), .a(u7_ff), .b(u7_ff), .p(uu_p));

   lpf_delay #(.W(64), .DEPTH(MUL_LAT + 1)) u_u_dly (
      .clock (clock),
      .ce    (ce),
      .din   (u7_ff),
      .dout  (u7_dly)
   );

   lpf_mul u_mul_s6 (.clock(clock), .ce(ce), .a(u2_ff), .b(u7_dly), .p(uuu_p));
   lpf_mul u_mul_g  (.clock(clock), .ce(ce), .a(s6b_ff), .b(hm_ff), .p(gp_p));
   lpf_mul u_mul_k  (.clock(clock), .ce(ce), .a({27'b0, eps48_ff}), .b(g_ff), .p(kp_p));

   lpf_delay #(.W(1), .DEPTH(2 * (MUL_LAT + 1))) u_gneg_dly (
      .clock (clock),
      .ce    (ce),
      .din   (gneg_ff),
      .dout  (gneg_k)
   );

   // Potential chain registers: u, u^2, s6, |s6 - 1/2| and its sign, g and k.
   always_ff @(posedge clock) begin
      if (ce) begin
         u7_ff   <= u7_in;
         u2_ff   <= cap_shr32(uu_p);
         s6_ff   <= cap_shr32(uuu_p);
         gneg_ff <= (s6_ff < HALF_Q32);
         hm_ff   <= (s6_ff < HALF_Q32) ? (HALF_Q32 - s6_ff) : (s6_ff - HALF_Q32);
         s6b_ff  <= s6_ff;
         g_ff    <= cap_shr32(gp_p);
         k_ff    <= cap_shr32(kp_p);
      end
   end

   // Pair data waits beside the potential chain.
   lpf_delay #(.W(165), .DEPTH(B_DLY)) u_b_dly (
      .clock (clock),
      .ce    (ce),
      .din   ({r2_6_ff, ad6_ff, neg6_ff, inr6_ff, calc6_ff}),
      .dout  (bund_b)
   );
   assign {r2_b, ad_b, neg_b, inr_b, calc_b} = bund_b;

   lpf_delay #(.W(70), .DEPTH(MUL_LAT + 1)) u_c_dly (
      .clock (clock),
      .ce    (ce),
      .din   ({r2_b, neg_b, inr_b, calc_b, gneg_k}),
      .dout  (bund_c)
   );
   assign {r2_c, neg_c, inr_c, calc_c, gneg_c} = bund_c;

   lpf_delay #(.W(6), .DEPTH(DIV_Q_W)) u_d_dly (
      .clock (clock),
      .ce    (ce),
      .din   ({neg_c, inr_c, calc_c, gneg_c}),
      .dout  (bund_d)
   );
   assign {neg_d, inr_d, calc_d, gneg_d} = bund_d;

   // Per-axis force: (k * |d| << FRAC_BITS) / r2.
   for (genvar c = 0; c < 3; c++) begin : g_force
      lpf_mul u_mul_f (
         .clock (clock),
         .ce    (ce),
         .a     (k_ff),
         .b     ({32'b0, ad_b[c]}),
         .p     (fp_p[c])
      );
      lpf_div #(.D_W(64), .Q_W(DIV_Q_W)) u_force_div (
         .clock  (clock),
         .ce     (ce),
         .num_hi (fnum_ff[c][127:64]),
         .num_lo (fnum_ff[c][63:0]),
         .den    (r2_c),
         .quo    (fq[c]),
         .ovf    (fovf[c])
      );
   end

   // Saturate the magnitudes, apply the sign, or give zero if calc_d is clear.
   always_comb begin
      logic [46:0] mag;
      for (int c = 0; c < 3; c++) begin
         fnum_in[c] = fp_p[c] << FRAC_BITS;
         mag = (fovf[c] || (fq[c] > 64'(FORCE_MAX))) ? FORCE_MAX : fq[c][46:0];
         if (!calc_d) begin
            force_in[c] = '0;
         end else if (neg_d[c] ^ gneg_d) begin
            force_in[c] = 48'(-{1'b0, mag});
         end else begin
            force_in[c] = {1'b0, mag};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         fnum_ff    <= fnum_in;
         force_ff   <= force_in;
         inr_out_ff <= inr_d;
      end
   end

endmodule

`default_nettype wire

/* tb/lpf_checker.sv */
// Beat monitor, force predictor and result scoreboard for the pair force pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lpf_checker
   import lpf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [223:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [143:0] rsp_tdata,
   input  wire logic [0:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [30:0]  csr_wdata,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic         in_range;
      logic [143:0] forces;
   } force_rec_type;

   localparam logic [30:0] ONE = 31'(1) << FRAC_BITS;

   logic [30:0]   box_len [3];
   logic [30:0]   sigma_len;
   logic [30:0]   eps_val;
   force_rec_type force_queue [$];

   // Unsigned value limited to a ceiling.
   function automatic logic [63:0] clip(input logic [127:0] x, input logic [63:0] lim);
      return (x > {64'd0, lim}) ? lim : x[63:0];
   endfunction

   // Expected force on atom i and interaction flag for one pair beat.
   function automatic force_rec_type pair_force(input logic [223:0] p);
      force_rec_type      res;
      logic signed [63:0] d [3];
      logic [63:0]        ad [3];
      logic [63:0]        r2, sigma2, cutoff, u, u2, s6, hm, g, k, mag, n, len;
      logic [64:0]        acc;
      logic               gneg, neg;
      res = '0;
      if (p[207:192] == p[223:208]) return res;
      r2 = 64'd0;
      for (int c = 0; c < 3; c++) begin
         d[c] = 64'(signed'(p[32*c +: 32])) - 64'(signed'(p[96 + 32*c +: 32]));
         len = {33'd0, box_len[c]};
         // Periodic minimum image, rounding half away from zero.
         if (len != 0) begin
            ad[c] = d[c][63] ? -d[c] : d[c];
            n = (2 * ad[c] + len) / (2 * len);
            d[c] = d[c][63] ? d[c] + signed'(n * len) : d[c] - signed'(n * len);
         end
         ad[c] = d[c][63] ? -d[c] : d[c];
         acc = {1'b0, r2} + {1'b0, ad[c] * ad[c]};
         r2 = acc[64] ? '1 : acc[63:0];
      end
      sigma2 = {33'd0, sigma_len} * {33'd0, sigma_len};
      cutoff = clip((128'(sigma2) * 128'(CBRT2_Q30)) >> 30, '1);
      if (!(r2 < cutoff)) return res;
      res.in_range = 1'b1;
      if (r2 == 0) return res;
      u    = clip((128'(sigma2) << 32) / 128'(r2), CAP63);
      u2   = clip((128'(u) * 128'(u)) >> 32, CAP63);
      s6   = clip((128'(u2) * 128'(u)) >> 32, CAP63);
      gneg = s6 < HALF_Q32;
      hm   = gneg ? HALF_Q32 - s6 : s6 - HALF_Q32;
      g    = clip((128'(s6) * 128'(hm)) >> 32, CAP63);
      k    = clip((128'(64'd48 * {33'd0, eps_val}) * 128'(g)) >> 32, CAP63);
      for (int c = 0; c < 3; c++) begin
         mag = clip(((128'(k) * 128'(ad[c])) << FRAC_BITS) / 128'(r2), {17'd0, FORCE_MAX});
         neg = d[c][63] != gneg;
         res.forces[48*c +: 48] = neg ? 48'(-mag) : mag[47:0];
      end
      return res;
   endfunction

   // Follow register writes, queue predictions and compare result beats.
   always @(posedge clock) begin
      force_rec_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         box_len = '{ONE, ONE, ONE};
         sigma_len = ONE;
         eps_val = ONE;
         force_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BOX_X:   box_len[0] = csr_wdata;
               CSR_BOX_Y:   box_len[1] = csr_wdata;
               CSR_BOX_Z:   box_len[2] = csr_wdata;
               CSR_SIGMA:   sigma_len = csr_wdata;
               CSR_EPSILON: eps_val = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) force_queue.push_back(pair_force(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (force_queue.size() == 0) begin
               $error("result beat with no pair outstanding");
               errs++;
            end else begin
               want = force_queue.pop_front();
               if (rsp_tdata[47:0] !== want.forces[47:0]) begin
                  $error("force_x expected %h actual %h", want.forces[47:0], rsp_tdata[47:0]);
                  errs++;
               end
               if (rsp_tdata[95:48] !== want.forces[95:48]) begin
                  $error("force_y expected %h actual %h", want.forces[95:48],
                         rsp_tdata[95:48]);
                  errs++;
               end
               if (rsp_tdata[143:96] !== want.forces[143:96]) begin
                  $error("force_z expected %h actual %h", want.forces[143:96],
                         rsp_tdata[143:96]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.in_range) begin
                  $error("in_range expected %b actual %b", want.in_range, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= force_queue.size();
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Stimulus, clocking and verdict for the pair force pipeline testbench.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import lpf_pkg::*;

   localparam int          WATCH_LIMIT = 5000;
   localparam int          SETTLE      = 400;
   localparam logic [30:0] ONE         = 31'd65536;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, chain_a, chain_b
   logic [223:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // force_x, force_y, force_z
   logic [143:0] rsp_tdata;
   // in_range
   logic [0:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [30:0]  csr_wdata;
   int           fail_count;
   int           pending;
   logic         calm;
   int           stall_left;
   int           quiet_cycles;
   logic [30:0]  cur_sigma;

   lj_pair_force_wca dut (.*);

   lpf_checker chk (.*);

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side back-pressure in short bursts.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [30:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_SIGMA) cur_sigma = value;
   endtask

   task automatic set_params(input logic [30:0] bx, input logic [30:0] by,
                             input logic [30:0] bz, input logic [30:0] sg,
                             input logic [30:0] ep);
      csr_write(CSR_BOX_X, bx);
      csr_write(CSR_BOX_Y, by);
      csr_write(CSR_BOX_Z, bz);
      csr_write(CSR_SIGMA, sg);
      csr_write(CSR_EPSILON, ep);
   endtask

   // One pair beat; valid stays high across back-to-back beats.
   task automatic send_pair(input logic [31:0] a [3], input logic [31:0] b [3],
                            input logic [15:0] ca, input logic [15:0] cb);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {cb, ca, b[2], b[1], b[0], a[2], a[1], a[0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_same(input logic [31:0] pa, input logic [31:0] pb,
                            input logic [15:0] ca, input logic [15:0] cb);
      logic [31:0] a [3];
      logic [31:0] b [3];
      a = '{pa, pa, pa};
      b = '{pb, pb, pb};
      send_pair(a, b, ca, cb);
   endtask

   // Mostly close pairs on different chains, the rest arbitrary.
   task automatic send_random(input int count);
      logic [31:0] a [3];
      logic [31:0] b [3];
      logic [63:0] reach;
      logic [15:0] ca, cb;
      for (int n = 0; n < count; n++) begin
         reach = 64'(cur_sigma) * 2 + 1;
         for (int c = 0; c < 3; c++) begin
            a[c] = $urandom;
            if ($urandom_range(0, 4) == 0) b[c] = $urandom;
            else b[c] = a[c] + 32'($urandom % reach) - 32'(reach >> 1);
         end
         ca = 16'($urandom);
         cb = ($urandom_range(0, 7) == 0) ? ca : 16'($urandom);
         send_pair(a, b, ca, cb);
      end
   endtask

   // Stop sending at once and wait until every pair has come out.
   task automatic drain;
      req_tvalid = 1'b0;
      while (pending != 0 || (rsp_tvalid === 1'b1)) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_BOX_X;
      csr_wdata = '0;
      cur_sigma = ONE;
      stall_left = 0;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pairs with reset parameters.
      send_same(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd65535);
      send_same(32'h8000_0000, 32'h7FFF_FFFF, 16'd65535, 16'd0);
      send_same(32'h0000_1234, 32'h0000_1234, 16'd7, 16'd7);
      send_same(32'h0000_4000, 32'h0000_4000, 16'd1, 16'd2);
      send_same(32'h0000_0001, 32'h0000_0000, 16'd1, 16'd2);
      send_same(32'hFFFF_FFFF, 32'h0000_0000, 16'd3, 16'd4);
      send_same(32'h0000_8000, 32'h0000_0000, 16'd3, 16'd4);
      send_same(32'hFFFF_8000, 32'h0000_0000, 16'd3, 16'd4);
      send_same(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
      drain;

      // Wide box: far, near-cutoff, close, coincident and random pairs.
      set_params(31'd655360, 31'd786432, 31'd524288, ONE, ONE);
      send_same(32'h0001_0000, 32'h0000_0000, 16'd1, 16'd2);
      send_same(32'h0000_A000, 32'h0000_0000, 16'd1, 16'd2);
      send_same(32'h0000_0100, 32'h0000_0000, 16'd1, 16'd2);
      send_same(32'h0001_0000, 32'h0001_0000, 16'd1, 16'd2);
      send_random(300);
      drain;

      // Zero box lengths with zero then unit epsilon, then zero sigma.
      set_params(31'd0, 31'd0, 31'd0, ONE, 31'd0);
      send_same(32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 16'd2);
      send_same(32'h0000_8000, 32'h0000_0000, 16'd1, 16'd2);
      drain;
      csr_write(CSR_EPSILON, ONE);
      send_same(32'h0000_8000, 32'h0000_0000, 16'd1, 16'd2);
      drain;
      csr_write(CSR_SIGMA, 31'd0);
      send_same(32'h0000_0000, 32'h0000_0000, 16'd1, 16'd2);
      send_random(20);
      drain;

      // Largest register values.
      set_params(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF);
      send_same(32'h0000_0001, 32'h0000_0000, 16'd1, 16'd2);
      send_random(300);
      drain;

      // Smallest box and zero epsilon.
      set_params(31'd1, 31'd1, 31'd1, 31'd1, 31'd0);
      send_random(200);
      drain;

      // Small sigma in a modest box.
      set_params(31'd196608, 31'd262144, 31'd131072, 31'd16384, 31'd163840);
      send_random(300);
      drain;

      // Final stretch without any idling.
      set_params(31'd1048576, 31'd1048576, 31'd1048576, ONE, ONE);
      calm = 1'b1;
      send_random(280);
      drain;

      if (pending != 0) $error("%0d expected results never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* lj_pair_force_wca.f */
rtl/lpf_pkg.sv
rtl/lpf_delay.sv
rtl/lpf_mul.sv
rtl/lpf_div.sv
rtl/lj_pair_force_wca.sv
tb/lpf_checker.sv
tb/tb_top.sv
